### sv/sgdm_pkg.sv
// ----------------------------------------------------------------------------
// sgdm_pkg
// shared types, constants and fixed-point helpers for the sgd momentum
// update unit
// ----------------------------------------------------------------------------
package sgdm_pkg;

  localparam int ELEMENT_COUNT = 4096;
  localparam int ADDR_W        = (ELEMENT_COUNT > 1) ? $clog2(ELEMENT_COUNT) : 1;

  localparam int IDX_W     = 12;
  localparam int VAL_W     = 32;
  localparam int COEF_W    = 24;
  localparam int PROD_W    = VAL_W + COEF_W;
  localparam int Q_SHIFT   = 24;
  localparam int SUM_W     = VAL_W + 2;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;

  localparam int OUT_FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W     = $clog2(OUT_FIFO_DEPTH);
  localparam int FIFO_CNT_W     = $clog2(OUT_FIFO_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOMENTUM_FACTOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_DECAY    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_USE_MOMENTUM    = 2'd3;

  localparam logic [PROD_W-1:0]       Q_HALF  = PROD_W'(1) << (Q_SHIFT - 1);
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(64'sh7FFF_FFFF);
  localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(-64'sh8000_0000);

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic signed [VAL_W-1:0]  val_t;
  typedef logic [VAL_W-1:0]         mag_t;
  typedef logic [COEF_W-1:0]        coef_t;
  typedef logic [PROD_W-1:0]        prod_t;
  typedef logic signed [VAL_W:0]    scaled_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef struct packed {
    val_t new_param;
    val_t new_momentum;
  } result_t;

  function automatic mag_t magnitude(val_t v);
    return v[VAL_W-1] ? mag_t'(-v) : mag_t'(v);
  endfunction

  function automatic prod_t scale_mag(val_t v, coef_t c);
    return prod_t'(magnitude(v)) * prod_t'(c);
  endfunction

  // rounds half away from zero, then restores the sign
  function automatic scaled_t round_scaled(prod_t p, logic neg);
    prod_t   t;
    scaled_t r;
    t = (p + Q_HALF) >> Q_SHIFT;
    r = scaled_t'(t[VAL_W:0]);
    return neg ? -r : r;
  endfunction

  function automatic val_t sat_val(sum_t s);
    if (s > SUM_MAX) begin
      return val_t'(SUM_MAX);
    end else if (s < SUM_MIN) begin
      return val_t'(SUM_MIN);
    end
    return s[VAL_W-1:0];
  endfunction

  function automatic logic in_store(idx_t i);
    return 64'(i) < 64'(ELEMENT_COUNT);
  endfunction

endpackage

### sv/sgdm_if.sv
// ----------------------------------------------------------------------------
// sgdm_if
// valid/ready channels for input elements and update results
// ----------------------------------------------------------------------------
interface sgdm_in_if;
  logic                valid;
  logic                ready;
  sgdm_pkg::idx_t      element_index;
  sgdm_pkg::val_t      param_value;
  sgdm_pkg::val_t      grad_value;

  modport source (output valid, output element_index, output param_value,
                  output grad_value, input ready);
  modport sink   (input valid, input element_index, input param_value,
                  input grad_value, output ready);
endinterface

interface sgdm_out_if;
  logic                valid;
  logic                ready;
  sgdm_pkg::val_t      new_param;
  sgdm_pkg::val_t      new_momentum;

  modport source (output valid, output new_param, output new_momentum, input ready);
  modport sink   (input valid, input new_param, input new_momentum, output ready);
endinterface

### sv/sgd_momentum_update_unit.sv
// ----------------------------------------------------------------------------
// sgd_momentum_update_unit
// sgd parameter update with optional momentum and weight decay, q8.24
// ----------------------------------------------------------------------------
// Takes one element per cycle unless held off by the clearing pass, an index
// hazard or a full result buffer, and gives one result per element. The momentum
// store is a single-port-read, single-port-write RAM updated read-modify-
// write; in momentum mode an element with the index of the one accepted in
// the cycle before waits, as its old momentum is still being formed. After
// reset the store is cleared one entry per cycle, during which no element is
// accepted; configuration writes are taken throughout. Up to eight results
// are held when the output side stalls before input transfers stop.
// ----------------------------------------------------------------------------
module sgd_momentum_update_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  sgdm_in_if.sink                                in_ch,
  sgdm_out_if.source                             out_ch,
  input  logic                                   cfg_wr_en,
  input  logic [sgdm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [sgdm_pkg::CFG_W-1:0]             cfg_data
);

  // configuration
  sgdm_pkg::coef_t learning_rate_r, momentum_factor_r, weight_decay_r;
  logic            use_momentum_r;

  // clearing pass and credit count
  logic                             clr_r, clr_nxt;
  sgdm_pkg::addr_t                  clr_addr_r, clr_addr_nxt;
  logic [sgdm_pkg::FIFO_CNT_W-1:0]  inflight_r, inflight_nxt;
  logic                             in_xfer, out_xfer, hazard;

  // pipeline
  logic             v1_r, v2_r, v3_r, v4_r, v5_r;
  sgdm_pkg::idx_t   idx1_r, idx2_r, idx3_r, idx4_r;
  logic             inr2_r, inr3_r, wr4_r;
  sgdm_pkg::val_t   param1_r, param2_r, param3_r, param4_r, param5_r;
  sgdm_pkg::val_t   grad1_r, grad2_r;
  sgdm_pkg::prod_t  wdprod2_r, mprod3_r, lprod5_r;
  logic             wdneg2_r, mneg3_r, lneg5_r;
  sgdm_pkg::val_t   old2_r, g3_r, mom4_r, step4_r, mom5_r;

  sgdm_pkg::val_t   ram_rdata, old1, g2, mom3_nxt, step3, new_param5;
  logic             inr1, wr3;
  logic             ram_wr_en;
  sgdm_pkg::addr_t  ram_wr_addr;
  sgdm_pkg::val_t   ram_wr_data;
  sgdm_pkg::result_t push_data;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learning_rate_r   <= '0;
      momentum_factor_r <= '0;
      weight_decay_r    <= '0;
      use_momentum_r    <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        sgdm_pkg::REG_LEARNING_RATE:   learning_rate_r   <= cfg_data;
        sgdm_pkg::REG_MOMENTUM_FACTOR: momentum_factor_r <= cfg_data;
        sgdm_pkg::REG_WEIGHT_DECAY:    weight_decay_r    <= cfg_data;
        sgdm_pkg::REG_USE_MOMENTUM:    use_momentum_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input side
  assign hazard   = v1_r && use_momentum_r && (in_ch.element_index == idx1_r);
  assign in_ch.ready = !clr_r && !hazard
                     && (inflight_r < sgdm_pkg::FIFO_CNT_W'(sgdm_pkg::OUT_FIFO_DEPTH));
  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_xfer = out_ch.valid && out_ch.ready;

  always_comb begin
    clr_nxt      = clr_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == sgdm_pkg::addr_t'(sgdm_pkg::ELEMENT_COUNT - 1)) begin
        clr_nxt = 1'b0;
      end
    end
    inflight_nxt = inflight_r + sgdm_pkg::FIFO_CNT_W'(in_xfer)
                 - sgdm_pkg::FIFO_CNT_W'(out_xfer);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
      inflight_r <= '0;
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      v4_r       <= 1'b0;
      v5_r       <= 1'b0;
    end else begin
      clr_r      <= clr_nxt;
      clr_addr_r <= clr_addr_nxt;
      inflight_r <= inflight_nxt;
      v1_r       <= in_xfer;
      v2_r       <= v1_r;
      v3_r       <= v2_r;
      v4_r       <= v3_r;
      v5_r       <= v4_r;
    end
  end

  // momentum store
  always_comb begin
    if (clr_r) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = clr_addr_r;
      ram_wr_data = '0;
    end else begin
      ram_wr_en   = wr3;
      ram_wr_addr = sgdm_pkg::addr_t'(idx3_r);
      ram_wr_data = mom3_nxt;
    end
  end

  sgdm_ram #(
    .WIDTH (sgdm_pkg::VAL_W),
    .DEPTH (sgdm_pkg::ELEMENT_COUNT)
  ) u_momentum_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (in_xfer),
    .rd_addr (sgdm_pkg::addr_t'(in_ch.element_index)),
    .rd_data (ram_rdata)
  );

  // stage 1: weight decay product, old momentum with forwarding
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      idx1_r   <= in_ch.element_index;
      param1_r <= in_ch.param_value;
      grad1_r  <= in_ch.grad_value;
    end
  end

  always_comb begin
    inr1 = sgdm_pkg::in_store(idx1_r);
    if (!inr1) begin
      old1 = '0;
    end else if (wr3 && (idx3_r == idx1_r)) begin
      old1 = mom3_nxt;
    end else if (v4_r && wr4_r && (idx4_r == idx1_r)) begin
      old1 = mom4_r;
    end else begin
      old1 = ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    idx2_r    <= idx1_r;
    inr2_r    <= inr1;
    param2_r  <= param1_r;
    grad2_r   <= grad1_r;
    wdprod2_r <= sgdm_pkg::scale_mag(param1_r, weight_decay_r);
    wdneg2_r  <= param1_r[sgdm_pkg::VAL_W-1];
    old2_r    <= old1;
  end

  // stage 2: gradient with decay, momentum product
  assign g2 = sgdm_pkg::sat_val(sgdm_pkg::SUM_W'(grad2_r)
            + sgdm_pkg::SUM_W'(sgdm_pkg::round_scaled(wdprod2_r, wdneg2_r)));

  always_ff @(posedge clk) begin
    idx3_r   <= idx2_r;
    inr3_r   <= inr2_r;
    param3_r <= param2_r;
    g3_r     <= g2;
    mprod3_r <= sgdm_pkg::scale_mag(old2_r, momentum_factor_r);
    mneg3_r  <= old2_r[sgdm_pkg::VAL_W-1];
  end

  // stage 3: new momentum, write back
  always_comb begin
    wr3 = v3_r && use_momentum_r && inr3_r;
    if (use_momentum_r) begin
      mom3_nxt = sgdm_pkg::sat_val(sgdm_pkg::SUM_W'(g3_r)
               + sgdm_pkg::SUM_W'(sgdm_pkg::round_scaled(mprod3_r, mneg3_r)));
      step3    = mom3_nxt;
    end else begin
      mom3_nxt = '0;
      step3    = g3_r;
    end
  end

  always_ff @(posedge clk) begin
    idx4_r   <= idx3_r;
    wr4_r    <= wr3;
    param4_r <= param3_r;
    mom4_r   <= mom3_nxt;
    step4_r  <= step3;
  end

  // stage 4: learning rate product
  always_ff @(posedge clk) begin
    param5_r <= param4_r;
    mom5_r   <= mom4_r;
    lprod5_r <= sgdm_pkg::scale_mag(step4_r, learning_rate_r);
    lneg5_r  <= step4_r[sgdm_pkg::VAL_W-1];
  end

  // stage 5: new parameter into the result buffer
  assign new_param5 = sgdm_pkg::sat_val(sgdm_pkg::SUM_W'(param5_r)
                    - sgdm_pkg::SUM_W'(sgdm_pkg::round_scaled(lprod5_r, lneg5_r)));

  always_comb begin
    push_data.new_param    = new_param5;
    push_data.new_momentum = mom5_r;
  end

  sgdm_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (v5_r),
    .push_data (push_data),
    .out_ch    (out_ch)
  );

  // checks
  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= sgdm_pkg::FIFO_CNT_W'(sgdm_pkg::OUT_FIFO_DEPTH))
    else $error("more results in flight than the buffer holds");

  a_no_work_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !(v1_r || v2_r || v3_r || v4_r || v5_r))
    else $error("element in flight during the clearing pass");

  a_same_index_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r && use_momentum_r) |-> (idx1_r != idx2_r))
    else $error("back-to-back transfer to one momentum entry");

  a_plain_mode_momentum: assert property (@(posedge clk) disable iff (!rst_n)
    (v5_r && !use_momentum_r) |-> (mom5_r == '0))
    else $error("momentum result not zero in plain mode");

endmodule

### sv/sgdm_ram.sv
// ----------------------------------------------------------------------------
// sgdm_ram
// generic single-write, single-read memory with registered read data
// (read-before-write on a same-address collision)
// ----------------------------------------------------------------------------
module sgdm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic                                        rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

### sv/sgdm_out_fifo.sv
// ----------------------------------------------------------------------------
// sgdm_out_fifo
// result buffer between the update pipeline and the output channel
// ----------------------------------------------------------------------------
module sgdm_out_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sgdm_pkg::result_t   push_data,
  sgdm_out_if.source          out_ch
);

  sgdm_pkg::result_t                     mem_r [sgdm_pkg::OUT_FIFO_DEPTH];
  logic [sgdm_pkg::FIFO_PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [sgdm_pkg::FIFO_PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [sgdm_pkg::FIFO_CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                                  pop;

  assign out_ch.valid        = (cnt_r != '0);
  assign out_ch.new_param    = mem_r[rd_ptr_r].new_param;
  assign out_ch.new_momentum = mem_r[rd_ptr_r].new_momentum;
  assign pop                 = out_ch.valid && out_ch.ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + sgdm_pkg::FIFO_CNT_W'(push) - sgdm_pkg::FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### tb/sgdm_update_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sgdm_update_checker
// Watches the element and result channels and the register port of the sgd
// momentum update unit. It keeps its own copy of the coefficients and of the
// momentum store, works out the update for every element transfer and
// compares each result transfer, field by field, with the oldest update
// still outstanding.
// ----------------------------------------------------------------------------
module sgdm_update_checker
  import sgdm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  sgdm_in_if                   in_mon,
  sgdm_out_if                  out_mon,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int unsigned          pending,
  output int unsigned          fail_count
);

  localparam longint WORD_MAX = 64'sh7FFF_FFFF;
  localparam longint WORD_MIN = -64'sh8000_0000;
  localparam longint unsigned ROUND_HALF = 64'd8388608;

  coef_t       lr_q;
  coef_t       mf_q;
  coef_t       wd_q;
  logic        use_mom_q;
  val_t        velocity_mirror [ELEMENT_COUNT];
  result_t     expected_updates [$];
  int unsigned errors;

  function automatic longint clip_word(longint v);
    if (v > WORD_MAX) begin
      return WORD_MAX;
    end
    if (v < WORD_MIN) begin
      return WORD_MIN;
    end
    return v;
  endfunction

  // q0.24 scaling, rounded half away from zero
  function automatic longint scale_q24(longint v, coef_t c);
    longint unsigned mag;
    longint unsigned prod;
    mag  = (v < 0) ? -v : v;
    prod = (mag * 64'(c) + ROUND_HALF) >> 24;
    return (v < 0) ? -longint'(prod) : longint'(prod);
  endfunction

  function automatic result_t predict_update(idx_t idx, val_t param, val_t grad);
    longint  decayed;
    longint  prev;
    longint  vel;
    longint  step;
    logic    stored;
    result_t r;
    stored  = int'(idx) < ELEMENT_COUNT;
    decayed = clip_word(longint'(grad) + scale_q24(longint'(param), wd_q));
    vel     = 0;
    step    = decayed;
    if (use_mom_q) begin
      // an index beyond the store reads as zero and is not written back
      prev = stored ? longint'(velocity_mirror[idx]) : 64'sd0;
      vel  = clip_word(scale_q24(prev, mf_q) + decayed);
      if (stored) begin
        velocity_mirror[idx] = val_t'(vel);
      end
      step = vel;
    end
    r.new_param    = val_t'(clip_word(longint'(param) - scale_q24(step, lr_q)));
    r.new_momentum = val_t'(vel);
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      expected_updates.delete();
      foreach (velocity_mirror[i]) velocity_mirror[i] = '0;
      lr_q      = '0;
      mf_q      = '0;
      wd_q      = '0;
      use_mom_q = 1'b0;
      errors    = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_LEARNING_RATE:   lr_q = cfg_data[COEF_W-1:0];
          REG_MOMENTUM_FACTOR: mf_q = cfg_data[COEF_W-1:0];
          REG_WEIGHT_DECAY:    wd_q = cfg_data[COEF_W-1:0];
          REG_USE_MOMENTUM:    use_mom_q = cfg_data[0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_updates.size() == 0) begin
          errors++;
          $error("result transfer with no update outstanding: new_param %0d new_momentum %0d",
                 out_mon.new_param, out_mon.new_momentum);
        end else begin
          want = expected_updates.pop_front();
          if (out_mon.new_param !== want.new_param) begin
            errors++;
            $error("new_param: expected %0d, got %0d", want.new_param, out_mon.new_param);
          end
          if (out_mon.new_momentum !== want.new_momentum) begin
            errors++;
            $error("new_momentum: expected %0d, got %0d", want.new_momentum,
                   out_mon.new_momentum);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_updates.push_back(predict_update(in_mon.element_index, in_mon.param_value,
                                                  in_mon.grad_value));
      end
    end
    pending    <= expected_updates.size();
    fail_count <= errors;
  end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the sgd momentum update unit. A directed set of elements
// covers the value extremes, exact rounding halves, saturation and repeated
// momentum updates of one entry, in both modes. Then random elements run
// under a series of coefficient settings, with idle and stall patterns on
// both channels, repeated indices to exercise the momentum store, and a
// drain of all results before each register change.
// ----------------------------------------------------------------------------
module tb;
  import sgdm_pkg::*;

  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 50;
  localparam val_t  VAL_TOP    = 32'sh7FFF_FFFF;
  localparam val_t  VAL_BOTTOM = 32'sh8000_0000;
  localparam val_t  VAL_ONE    = 32'sh0100_0000;
  localparam val_t  VAL_HALF   = 32'sh0080_0000;
  localparam coef_t COEF_FULL  = 24'hFF_FFFF;
  localparam coef_t COEF_HALF  = 24'h80_0000;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int unsigned          pending;
  int unsigned          fail_count;
  int unsigned          quiet_cycles;
  int unsigned          in_idle_pct;
  int unsigned          out_stall_pct;

  sgdm_in_if  in_ch ();
  sgdm_out_if out_ch ();

  sgd_momentum_update_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sgdm_update_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .fail_count (fail_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic apply_settings(coef_t lr, coef_t mf, coef_t wd, logic mom);
    write_reg(REG_LEARNING_RATE, lr);
    write_reg(REG_MOMENTUM_FACTOR, mf);
    write_reg(REG_WEIGHT_DECAY, wd);
    write_reg(REG_USE_MOMENTUM, CFG_W'(mom));
    cfg_wr_en <= 1'b0;
  endtask

  task automatic push_element(idx_t idx, val_t param, val_t grad);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.element_index <= idx;
    in_ch.param_value   <= param;
    in_ch.grad_value    <= grad;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic val_t pick_value();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 4) begin
      return val_t'($urandom_range(32'h0800_0000)) - val_t'(32'h0400_0000);
    end
    if (r < 8) begin
      return val_t'($urandom());
    end
    case ($urandom_range(4))
      0:       return VAL_TOP;
      1:       return VAL_BOTTOM;
      2:       return '0;
      3:       return -1;
      default: return 1;
    endcase
  endfunction

  function automatic coef_t pick_coef();
    int unsigned r;
    r = $urandom_range(5);
    if (r == 0) begin
      return '0;
    end
    if (r == 1) begin
      return COEF_FULL;
    end
    return coef_t'($urandom_range(COEF_FULL));
  endfunction

  initial begin
    idx_t        idx;
    int unsigned r;
    rst_n               = 1'b0;
    cfg_wr_en           = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    in_ch.valid         = 1'b0;
    in_ch.element_index = '0;
    in_ch.param_value   = '0;
    in_ch.grad_value    = '0;
    in_idle_pct         = 25;
    out_stall_pct       = 78;
    idx                 = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // plain mode, full coefficients: extremes and saturation
    apply_settings(COEF_FULL, '0, COEF_FULL, 1'b0);
    push_element(12'd0, VAL_TOP, VAL_TOP);
    push_element(12'd1, VAL_BOTTOM, VAL_BOTTOM);
    push_element(12'd2, '0, '0);
    push_element(12'd3, VAL_TOP, VAL_BOTTOM);
    push_element(12'd4, VAL_BOTTOM, VAL_TOP);
    push_element(12'd5, -1, 1);
    push_element(12'd4095, VAL_ONE, VAL_HALF);
    wait_drained();

    // exact rounding halves, momentum on one entry
    apply_settings(COEF_HALF, COEF_HALF, COEF_HALF, 1'b1);
    push_element(12'd7, 1, 1);
    push_element(12'd7, -1, -3);
    push_element(12'd7, 3, '0);
    push_element(12'd4095, -1, -1);
    push_element(12'd7, VAL_ONE, -VAL_HALF);
    wait_drained();

    // momentum driven into saturation and back
    apply_settings(COEF_FULL, COEF_FULL, '0, 1'b1);
    push_element(12'd9, '0, VAL_TOP);
    push_element(12'd9, '0, VAL_TOP);
    push_element(12'd9, '0, VAL_TOP);
    push_element(12'd9, VAL_BOTTOM, VAL_BOTTOM);
    push_element(12'd9, VAL_BOTTOM, VAL_BOTTOM);
    push_element(12'd9, VAL_BOTTOM, VAL_BOTTOM);
    push_element(12'd4095, VAL_TOP, VAL_TOP);
    push_element(12'd4095, VAL_BOTTOM, VAL_TOP);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 3) begin
        in_idle_pct   = 78;
        out_stall_pct = 25;
      end else if (p == 6) begin
        in_idle_pct   = 0;
        out_stall_pct = 0;
      end
      if (p == 2) begin
        apply_settings(COEF_FULL, COEF_FULL, COEF_FULL, 1'b1);
      end else if (p == 4) begin
        apply_settings('0, '0, '0, 1'b1);
      end else begin
        apply_settings(pick_coef(), pick_coef(), pick_coef(), (p % 3) != 1);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(9);
        if (r >= 7) begin
          idx = idx_t'($urandom_range(ELEMENT_COUNT - 1));
        end else if (r >= 4) begin
          idx = idx_t'($urandom_range(7));
        end
        push_element(idx, pick_value(), pick_value());
      end
      wait_drained();
    end

    repeat (12) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
